/* design/scba_pkg.sv */
// Shared types, constants and helpers of the size-class block allocator.
package scba_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int NUM_CLASSES = 4;
    localparam int NUM_REGS    = 4;
    localparam int COUNT_W     = 7;
    localparam int SLOT_W      = 6;
    localparam int CLASS_W     = 2;
    localparam int BYTES_W     = 16;
    localparam int STAT_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int STACK_DEPTH = NUM_CLASSES * MAX_BLOCKS;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int BASE_BYTES  = 64;
    localparam int PCT_FULL    = 100;
    localparam int PCT_LIMIT   = 90;
    localparam int PCT_W       = COUNT_W + 7;

    localparam logic [NUM_REGS-1:0][COUNT_W-1:0] CFG_RESET = {7'd4, 7'd8, 7'd16, 7'd16};

    typedef enum logic [2:0] {
        KIND_ALLOC       = 3'd0,
        KIND_FREE        = 3'd1,
        KIND_STATS_READ  = 3'd2,
        KIND_STATS_RESET = 3'd3,
        KIND_INIT        = 3'd4,
        KIND_DEINIT      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_DISABLED  = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_NULL      = 3'd4,
        ST_HEAP_FREE = 3'd5,
        ST_BAD_STATE = 3'd6,
        ST_BAD_ARG   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        POOL_IDLE  = 3'd0,
        POOL_INIT  = 3'd1,
        POOL_ALLOC = 3'd2,
        POOL_FAIL  = 3'd3,
        POOL_FREE  = 3'd4,
        POOL_CLEAR = 3'd5
    } pool_op_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [BYTES_W-1:0] request_bytes;
        logic [CLASS_W-1:0] size_class;
        logic [SLOT_W-1:0]  block_slot;
    } alloc_req_t;

    typedef struct packed {
        status_t            status;
        logic [CLASS_W-1:0] granted_class;
        logic [SLOT_W-1:0]  granted_slot;
        logic [COUNT_W-1:0] pool_capacity;
        logic [COUNT_W-1:0] blocks_in_use;
        logic [COUNT_W-1:0] blocks_available;
        logic [STAT_W-1:0]  alloc_count;
        logic [STAT_W-1:0]  free_count;
        logic [STAT_W-1:0]  failure_count;
        logic [COUNT_W-1:0] peak_in_use;
        logic               healthy;
    } alloc_rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] capacity;
        logic [COUNT_W-1:0] fresh;
        logic [COUNT_W-1:0] depth;
        logic [COUNT_W-1:0] in_use;
        logic [COUNT_W-1:0] peak;
        logic [STAT_W-1:0]  allocs;
        logic [STAT_W-1:0]  frees;
        logic [STAT_W-1:0]  fails;
        logic               ok;
    } pool_stat_t;

    function automatic logic [BYTES_W:0] class_bytes(input int c);
        return (BYTES_W + 1)'(BASE_BYTES) << c;
    endfunction

endpackage

/* design/scba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/scba_pool.sv */
// Bookkeeping of one size-class pool: counts, high-water mark and health.
module scba_pool
    import scba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pool_op_t           op,
    input  logic [COUNT_W-1:0] init_blocks,
    output pool_stat_t         stat
);

    logic [COUNT_W-1:0] cap_reg, cap_next;
    logic [COUNT_W-1:0] fresh_reg, fresh_next;
    logic [COUNT_W-1:0] depth_reg, depth_next;
    logic [COUNT_W-1:0] in_use_reg, in_use_next;
    logic [COUNT_W-1:0] peak_reg, peak_next;
    logic [STAT_W-1:0]  allocs_reg, allocs_next;
    logic [STAT_W-1:0]  frees_reg, frees_next;
    logic [STAT_W-1:0]  fails_reg, fails_next;
    logic [PCT_W-1:0]   used_scaled;
    logic [PCT_W-1:0]   limit_scaled;

    always_comb
    begin
        cap_next    = cap_reg;
        fresh_next  = fresh_reg;
        depth_next  = depth_reg;
        in_use_next = in_use_reg;
        peak_next   = peak_reg;
        allocs_next = allocs_reg;
        frees_next  = frees_reg;
        fails_next  = fails_reg;
        unique case (op)
            POOL_INIT:
            begin
                if (init_blocks > COUNT_W'(MAX_BLOCKS))
                begin
                    cap_next = COUNT_W'(MAX_BLOCKS);
                end
                else
                begin
                    cap_next = init_blocks;
                end
                fresh_next  = cap_next;
                depth_next  = '0;
                in_use_next = '0;
                peak_next   = '0;
                allocs_next = '0;
                frees_next  = '0;
                fails_next  = '0;
            end
            POOL_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - 1'b1;
                end
                else
                begin
                    fresh_next = fresh_reg - 1'b1;
                end
                in_use_next = in_use_reg + 1'b1;
                allocs_next = allocs_reg + 1'b1;
                if (in_use_next > peak_reg)
                begin
                    peak_next = in_use_next;
                end
            end
            POOL_FAIL:
            begin
                fails_next = fails_reg + 1'b1;
            end
            POOL_FREE:
            begin
                depth_next  = depth_reg + 1'b1;
                in_use_next = in_use_reg - 1'b1;
                frees_next  = frees_reg + 1'b1;
            end
            POOL_CLEAR:
            begin
                if (cap_reg != '0)
                begin
                    allocs_next = '0;
                    frees_next  = '0;
                    fails_next  = '0;
                    peak_next   = in_use_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= '0;
            fresh_reg  <= '0;
            depth_reg  <= '0;
            in_use_reg <= '0;
            peak_reg   <= '0;
            allocs_reg <= '0;
            frees_reg  <= '0;
            fails_reg  <= '0;
        end
        else
        begin
            cap_reg    <= cap_next;
            fresh_reg  <= fresh_next;
            depth_reg  <= depth_next;
            in_use_reg <= in_use_next;
            peak_reg   <= peak_next;
            allocs_reg <= allocs_next;
            frees_reg  <= frees_next;
            fails_reg  <= fails_next;
        end
    end

    // Over the limit when in_use / capacity, rounded down, exceeds the percentage.
    assign used_scaled  = PCT_W'(in_use_reg) * PCT_W'(PCT_FULL);
    assign limit_scaled = PCT_W'(cap_reg) * PCT_W'(PCT_LIMIT + 1);

    always_comb
    begin
        stat.capacity = cap_reg;
        stat.fresh    = fresh_reg;
        stat.depth    = depth_reg;
        stat.in_use   = in_use_reg;
        stat.peak     = peak_reg;
        stat.allocs   = allocs_reg;
        stat.frees    = frees_reg;
        stat.fails    = fails_reg;
        stat.ok       = (cap_reg == '0) || ((used_scaled < limit_scaled) && (fails_reg == '0));
    end

endmodule

/* design/size_class_block_allocator_unit.sv */
// Top level of the size-class block allocator: request decode, free stack and response stage.
//
// The unit accepts one request per clock cycle unless rsp_ready holds back a waiting response:
// the request is held in an input register, decoded against the pool counters in one
// pass, and its response is captured in an output register while the free-stack RAM
// delivers the popped block index on its registered read port. Pool counters and the
// free stack are updated as the request leaves the input register, so back-to-back
// requests see each other's effects. A waiting response holds the request in the input
// register, which then blocks the next request. The free stack needs no clearing after
// reset; configuration takes effect at the next init request.
module size_class_block_allocator_unit
    import scba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  alloc_req_t           req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output alloc_rsp_t           rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    logic [NUM_REGS-1:0][COUNT_W-1:0] cfg_reg;

    logic       s1_valid_reg;
    alloc_req_t s1_item_reg;
    logic       s2_valid_reg;
    alloc_rsp_t s2_rsp_reg;
    logic       s2_from_ram_reg;
    logic       ready_reg;

    logic       s1_advance;
    alloc_rsp_t dec_rsp;
    logic       dec_from_ram;
    logic       ready_next;
    pool_op_t   dec_op [NUM_CLASSES];
    pool_op_t   pool_op [NUM_CLASSES];
    pool_stat_t pool_stat [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] pool_ok;

    logic                ram_we;
    logic [STACK_AW-1:0] ram_waddr;
    logic [SLOT_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [STACK_AW-1:0] ram_raddr;
    logic [SLOT_W-1:0]   ram_rdata;
    logic                dec_we;
    logic                dec_re;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CLASSES; g++)
        begin : g_pool
            assign pool_op[g] = s1_advance ? dec_op[g] : POOL_IDLE;
            scba_pool u_pool (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (pool_op[g]),
                .init_blocks ((g < NUM_REGS) ? cfg_reg[g] : COUNT_W'(0)),
                .stat        (pool_stat[g])
            );
            assign pool_ok[g] = pool_stat[g].ok;
        end
    endgenerate

    scba_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s1_advance = s1_valid_reg && (!s2_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign ram_we     = s1_advance && dec_we;
    assign ram_re     = s1_advance && dec_re;

    always_comb
    begin
        logic [CLASS_W-1:0] sel;
        logic               fit;
        logic [CLASS_W-1:0] cls;
        logic [COUNT_W-1:0] depth_m1;
        logic [COUNT_W-1:0] fresh_m1;
        pool_stat_t         ps;
        pool_stat_t         pc;

        dec_rsp      = '0;
        dec_rsp.status = ST_OK;
        dec_from_ram = 1'b0;
        dec_we       = 1'b0;
        dec_re       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = s1_item_reg.block_slot;
        ram_raddr    = '0;
        ready_next   = ready_reg;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            dec_op[c] = POOL_IDLE;
        end

        sel = '0;
        fit = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if ({1'b0, s1_item_reg.request_bytes} <= class_bytes(c))
            begin
                sel = CLASS_W'(c);
                fit = 1'b1;
            end
        end
        cls      = s1_item_reg.size_class;
        ps       = pool_stat[sel];
        pc       = pool_stat[cls];
        depth_m1 = ps.depth - 1'b1;
        fresh_m1 = ps.fresh - 1'b1;

        case (kind_t'(s1_item_reg.kind))
            KIND_ALLOC:
            begin
                if (!ready_reg || (s1_item_reg.request_bytes == '0))
                begin
                    dec_rsp.status = ST_NULL;
                end
                else if (!fit)
                begin
                    dec_rsp.status = ST_TOO_LARGE;
                end
                else
                begin
                    dec_rsp.granted_class = sel;
                    if (ps.capacity == '0)
                    begin
                        dec_rsp.status = ST_DISABLED;
                    end
                    else if (ps.depth != '0)
                    begin
                        dec_re       = 1'b1;
                        ram_raddr    = {sel, depth_m1[SLOT_W-1:0]};
                        dec_from_ram = 1'b1;
                        dec_op[sel]  = POOL_ALLOC;
                    end
                    else if (ps.fresh != '0)
                    begin
                        dec_rsp.granted_slot = fresh_m1[SLOT_W-1:0];
                        dec_op[sel]          = POOL_ALLOC;
                    end
                    else
                    begin
                        dec_rsp.status = ST_EXHAUSTED;
                        dec_op[sel]    = POOL_FAIL;
                    end
                end
            end
            KIND_FREE:
            begin
                dec_rsp.granted_class = cls;
                if (!ready_reg || (int'(cls) >= NUM_CLASSES) || (pc.capacity == '0) ||
                    ({1'b0, s1_item_reg.block_slot} >= pc.capacity) || (pc.in_use == '0) ||
                    (pc.depth >= COUNT_W'(MAX_BLOCKS)))
                begin
                    dec_rsp.status = ST_HEAP_FREE;
                end
                else
                begin
                    dec_we      = 1'b1;
                    ram_waddr   = {cls, pc.depth[SLOT_W-1:0]};
                    dec_op[cls] = POOL_FREE;
                end
            end
            KIND_STATS_READ:
            begin
                dec_rsp.granted_class = cls;
                if (int'(cls) >= NUM_CLASSES)
                begin
                    dec_rsp.status = ST_BAD_ARG;
                end
                else if (!ready_reg)
                begin
                    dec_rsp.status = ST_BAD_STATE;
                end
                else if (pc.capacity != '0)
                begin
                    dec_rsp.pool_capacity    = pc.capacity;
                    dec_rsp.blocks_in_use    = pc.in_use;
                    dec_rsp.blocks_available = pc.capacity - pc.in_use;
                    dec_rsp.alloc_count      = pc.allocs;
                    dec_rsp.free_count       = pc.frees;
                    dec_rsp.failure_count    = pc.fails;
                    dec_rsp.peak_in_use      = pc.peak;
                end
            end
            KIND_STATS_RESET:
            begin
                if (!ready_reg)
                begin
                    dec_rsp.status = ST_BAD_STATE;
                end
                else
                begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        dec_op[c] = POOL_CLEAR;
                    end
                end
            end
            KIND_INIT:
            begin
                if (ready_reg)
                begin
                    dec_rsp.status = ST_BAD_STATE;
                end
                else
                begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        dec_op[c] = POOL_INIT;
                    end
                    ready_next = 1'b1;
                end
            end
            KIND_DEINIT:
            begin
                if (!ready_reg)
                begin
                    dec_rsp.status = ST_BAD_STATE;
                end
                else
                begin
                    ready_next = 1'b0;
                end
            end
            default:
            begin
                dec_rsp.status = ST_BAD_ARG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ready_reg    <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                s2_valid_reg <= 1'b1;
                ready_reg    <= ready_next;
            end
            else if (rsp_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
        if (s1_advance)
        begin
            s2_rsp_reg      <= dec_rsp;
            s2_from_ram_reg <= dec_from_ram;
        end
    end

    // Pool state already reflects the request being answered, so health is read from it.
    always_comb
    begin
        rsp              = s2_rsp_reg;
        rsp.granted_slot = s2_from_ram_reg ? ram_rdata : s2_rsp_reg.granted_slot;
        rsp.healthy      = ready_reg && (&pool_ok);
    end

    assign rsp_valid = s2_valid_reg;

endmodule

/* bench/tb_size_class_block_allocator_unit.sv */
// Self-checking bench for the size-class block allocator: a directed table, then random pool traffic.
module tb_size_class_block_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int REG_BLOCKS_CLASS0 = 0;
    localparam int REG_BLOCKS_CLASS3 = 3;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_PLANS       = 8;

    localparam logic [BYTES_W-1:0] SIZE_EDGES [10] =
        '{16'd1, 16'd63, 16'd64, 16'd65, 16'd128, 16'd129, 16'd256, 16'd257, 16'd512, 16'd513};

    // Each plan lists the block counts of classes 3, 2, 1, 0.
    localparam logic [NUM_REGS-1:0][COUNT_W-1:0] POOL_PLANS [NUM_PLANS] = '{
        {7'd1,  7'd2,  7'd64,  7'd0},
        {7'd64, 7'd64, 7'd64,  7'd64},
        {7'd0,  7'd2,  7'd0,   7'd1},
        {7'd3,  7'd64, 7'd0,   7'd127},
        {7'd0,  7'd0,  7'd0,   7'd0},
        {7'd2,  7'd1,  7'd3,   7'd2},
        {7'd4,  7'd8,  7'd16,  7'd16},
        {7'd127, 7'd127, 7'd127, 7'd127}
    };

    localparam logic [NUM_REGS-1:0][COUNT_W-1:0] DIRECTED_POOLS = {7'd1, 7'd8, 7'd0, 7'd16};

    typedef struct packed {
        logic [2:0]         kind;
        logic [BYTES_W-1:0] request_bytes;
        logic [CLASS_W-1:0] size_class;
        logic [SLOT_W-1:0]  block_slot;
        bit                 typed;
        status_t            status;
        logic [CLASS_W-1:0] class_out;
        bit                 healthy;
    } directed_row_t;

    localparam int NUM_ROWS = 26;

    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{KIND_ALLOC,       16'd64,    2'd0, 6'd0,  1'b1, ST_NULL,      2'd0, 1'b0},
        '{KIND_FREE,        16'd0,     2'd1, 6'd0,  1'b1, ST_HEAP_FREE, 2'd1, 1'b0},
        '{KIND_STATS_READ,  16'd0,     2'd3, 6'd0,  1'b1, ST_BAD_STATE, 2'd3, 1'b0},
        '{KIND_STATS_RESET, 16'd0,     2'd0, 6'd0,  1'b1, ST_BAD_STATE, 2'd0, 1'b0},
        '{KIND_DEINIT,      16'd0,     2'd0, 6'd0,  1'b1, ST_BAD_STATE, 2'd0, 1'b0},
        '{KIND_SPARE6,      16'd0,     2'd0, 6'd0,  1'b1, ST_BAD_ARG,   2'd0, 1'b0},
        '{KIND_SPARE7,      16'hFFFF,  2'd3, 6'd63, 1'b1, ST_BAD_ARG,   2'd0, 1'b0},
        '{KIND_INIT,        16'd0,     2'd0, 6'd0,  1'b1, ST_OK,        2'd0, 1'b1},
        '{KIND_INIT,        16'd0,     2'd0, 6'd0,  1'b1, ST_BAD_STATE, 2'd0, 1'b1},
        '{KIND_ALLOC,       16'd0,     2'd0, 6'd0,  1'b1, ST_NULL,      2'd0, 1'b1},
        '{KIND_ALLOC,       16'hFFFF,  2'd0, 6'd0,  1'b1, ST_TOO_LARGE, 2'd0, 1'b1},
        '{KIND_ALLOC,       16'd513,   2'd0, 6'd0,  1'b1, ST_TOO_LARGE, 2'd0, 1'b1},
        '{KIND_ALLOC,       16'd65,    2'd0, 6'd0,  1'b1, ST_DISABLED,  2'd1, 1'b1},
        '{KIND_ALLOC,       16'd1,     2'd0, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_ALLOC,       16'd256,   2'd0, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_FREE,        16'd0,     2'd0, 6'd63, 1'b1, ST_HEAP_FREE, 2'd0, 1'b1},
        '{KIND_FREE,        16'd0,     2'd0, 6'd15, 1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_FREE,        16'd0,     2'd2, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_FREE,        16'd0,     2'd2, 6'd3,  1'b1, ST_HEAP_FREE, 2'd2, 1'b1},
        '{KIND_ALLOC,       16'd33,    2'd0, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_ALLOC,       16'd512,   2'd0, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_ALLOC,       16'd300,   2'd0, 6'd0,  1'b1, ST_EXHAUSTED, 2'd3, 1'b0},
        '{KIND_STATS_READ,  16'd0,     2'd3, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_STATS_READ,  16'd0,     2'd1, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_STATS_RESET, 16'd0,     2'd0, 6'd0,  1'b0, ST_OK,        2'd0, 1'b0},
        '{KIND_DEINIT,      16'd0,     2'd0, 6'd0,  1'b1, ST_OK,        2'd0, 1'b0}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    alloc_req_t           req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    alloc_rsp_t           rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    size_class_block_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [COUNT_W-1:0] cfg_shadow [NUM_REGS] = '{7'd16, 7'd16, 7'd8, 7'd4};
    bit                 pools_up = 1'b0;
    logic [COUNT_W-1:0] cap        [NUM_CLASSES] = '{default: '0};
    logic [COUNT_W-1:0] fresh_left [NUM_CLASSES] = '{default: '0};
    logic [COUNT_W-1:0] freed_top  [NUM_CLASSES] = '{default: '0};
    logic [COUNT_W-1:0] used       [NUM_CLASSES] = '{default: '0};
    logic [COUNT_W-1:0] high_mark  [NUM_CLASSES] = '{default: '0};
    logic [STAT_W-1:0]  n_alloc    [NUM_CLASSES] = '{default: '0};
    logic [STAT_W-1:0]  n_free     [NUM_CLASSES] = '{default: '0};
    logic [STAT_W-1:0]  n_fail     [NUM_CLASSES] = '{default: '0};
    logic [SLOT_W-1:0]  freed_slots [NUM_CLASSES][MAX_BLOCKS];
    logic [SLOT_W-1:0]  live_slots  [NUM_CLASSES][$];

    alloc_rsp_t pending [$];

    bit steady = 1'b0;
    int errors = 0;
    int checked = 0;
    int sent = 0;
    int settings_done = 0;
    int grants = 0;
    int exhausted = 0;
    int rejected_frees = 0;
    int unhealthy = 0;
    int cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic alloc_rsp_t pool_outcome(input alloc_req_t q);
        alloc_rsp_t o;
        int c;
        int k;
        o = '0;
        o.status = ST_OK;
        case (q.kind)
            KIND_ALLOC:
            begin
                if (!pools_up || q.request_bytes == 0)
                begin
                    o.status = ST_NULL;
                end
                else
                begin
                    c = 0;
                    while (c < NUM_CLASSES && int'(q.request_bytes) > (BASE_BYTES << c))
                        c++;
                    if (c == NUM_CLASSES)
                    begin
                        o.status = ST_TOO_LARGE;
                    end
                    else
                    begin
                        o.granted_class = CLASS_W'(c);
                        if (cap[c] == 0)
                        begin
                            o.status = ST_DISABLED;
                        end
                        else if (freed_top[c] > 0)
                        begin
                            freed_top[c]--;
                            o.granted_slot = freed_slots[c][freed_top[c]];
                        end
                        else if (fresh_left[c] > 0)
                        begin
                            fresh_left[c]--;
                            o.granted_slot = fresh_left[c][SLOT_W-1:0];
                        end
                        else
                        begin
                            n_fail[c]++;
                            o.status = ST_EXHAUSTED;
                        end
                        if (o.status == ST_OK)
                        begin
                            used[c]++;
                            n_alloc[c]++;
                            if (used[c] > high_mark[c])
                                high_mark[c] = used[c];
                            live_slots[c].push_back(o.granted_slot);
                        end
                    end
                end
            end
            KIND_FREE:
            begin
                c = q.size_class;
                o.granted_class = q.size_class;
                if (!pools_up || cap[c] == 0 || q.block_slot >= cap[c] || used[c] == 0 ||
                    freed_top[c] >= MAX_BLOCKS)
                begin
                    o.status = ST_HEAP_FREE;
                end
                else
                begin
                    freed_slots[c][freed_top[c]] = q.block_slot;
                    freed_top[c]++;
                    used[c]--;
                    n_free[c]++;
                    for (k = 0; k < live_slots[c].size(); k++)
                    begin
                        if (live_slots[c][k] == q.block_slot)
                        begin
                            live_slots[c].delete(k);
                            break;
                        end
                    end
                end
            end
            KIND_STATS_READ:
            begin
                c = q.size_class;
                o.granted_class = q.size_class;
                if (!pools_up)
                begin
                    o.status = ST_BAD_STATE;
                end
                else if (cap[c] != 0)
                begin
                    o.pool_capacity    = cap[c];
                    o.blocks_in_use    = used[c];
                    o.blocks_available = cap[c] - used[c];
                    o.alloc_count      = n_alloc[c];
                    o.free_count       = n_free[c];
                    o.failure_count    = n_fail[c];
                    o.peak_in_use      = high_mark[c];
                end
            end
            KIND_STATS_RESET:
            begin
                if (!pools_up)
                begin
                    o.status = ST_BAD_STATE;
                end
                else
                begin
                    for (c = 0; c < NUM_CLASSES; c++)
                    begin
                        if (cap[c] != 0)
                        begin
                            n_alloc[c]   = '0;
                            n_free[c]    = '0;
                            n_fail[c]    = '0;
                            high_mark[c] = used[c];
                        end
                    end
                end
            end
            KIND_INIT:
            begin
                if (pools_up)
                begin
                    o.status = ST_BAD_STATE;
                end
                else
                begin
                    for (c = 0; c < NUM_CLASSES; c++)
                    begin
                        cap[c] = (cfg_shadow[c] > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS)
                                                                : cfg_shadow[c];
                        fresh_left[c] = cap[c];
                        freed_top[c]  = '0;
                        used[c]       = '0;
                        high_mark[c]  = '0;
                        n_alloc[c]    = '0;
                        n_free[c]     = '0;
                        n_fail[c]     = '0;
                        live_slots[c].delete();
                    end
                    pools_up = 1'b1;
                end
            end
            KIND_DEINIT:
            begin
                if (!pools_up)
                    o.status = ST_BAD_STATE;
                else
                    pools_up = 1'b0;
            end
            default:
            begin
                o.status = ST_BAD_ARG;
            end
        endcase
        o.healthy = pools_up;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            if (cap[c] != 0 && ((int'(used[c]) * PCT_FULL) / int'(cap[c]) > PCT_LIMIT ||
                                n_fail[c] != 0))
                o.healthy = 1'b0;
        end
        return o;
    endfunction

    function automatic alloc_req_t next_request(input int alloc_share);
        alloc_req_t q;
        logic [31:0] noise;
        int roll;
        int pick;
        int c;
        noise = $urandom;
        q = noise[$bits(alloc_req_t)-1:0];
        roll = $urandom_range(0, 99);
        if (!pools_up && $urandom_range(0, 3) != 0)
        begin
            q.kind = KIND_INIT;
        end
        else if (roll < alloc_share)
        begin
            q.kind = KIND_ALLOC;
            pick = $urandom_range(0, 19);
            if (pick < 14)
                q.request_bytes = BYTES_W'($urandom_range(1, 512));
            else if (pick < 17)
                q.request_bytes = SIZE_EDGES[$urandom_range(0, 9)];
            else if (pick < 19)
                q.request_bytes = BYTES_W'($urandom);
            else
                q.request_bytes = '0;
        end
        else if (roll < alloc_share + 30)
        begin
            q.kind = KIND_FREE;
            c = $urandom_range(0, NUM_CLASSES - 1);
            if ($urandom_range(0, 4) != 0 && live_slots[c].size() != 0)
            begin
                q.size_class = CLASS_W'(c);
                q.block_slot = live_slots[c][$urandom_range(0, live_slots[c].size() - 1)];
            end
        end
        else if (roll < 90)
            q.kind = KIND_STATS_READ;
        else if (roll < 93)
            q.kind = KIND_STATS_RESET;
        else if (roll < 96)
            q.kind = KIND_DEINIT;
        else if (roll < 98)
            q.kind = KIND_INIT;
        else
            q.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE6 : KIND_SPARE7;
        return q;
    endfunction

    task automatic send_request(input alloc_req_t q, input bit typed, input alloc_rsp_t typed_rsp);
        int gap;
        alloc_rsp_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= q;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        want = pool_outcome(q);
        if (typed)
            want = typed_rsp;
        pending.push_back(want);
        sent++;
        if (q.kind == KIND_ALLOC && want.status == ST_OK)
            grants++;
        if (want.status == ST_EXHAUSTED)
            exhausted++;
        if (want.status == ST_HEAP_FREE)
            rejected_frees++;
        if (!want.healthy)
            unhealthy++;
    endtask

    task automatic set_pools(input logic [NUM_REGS-1:0][COUNT_W-1:0] counts);
        for (int r = REG_BLOCKS_CLASS0; r <= REG_BLOCKS_CLASS3; r++)
        begin
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= counts[r];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            cfg_shadow[r] = counts[r];
        end
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic note_field(input string name, input logic [STAT_W-1:0] want,
                              input logic [STAT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic compare_response(input alloc_rsp_t want, input alloc_rsp_t got);
        note_field("status", STAT_W'(want.status), STAT_W'(got.status));
        note_field("granted_class", STAT_W'(want.granted_class), STAT_W'(got.granted_class));
        note_field("granted_slot", STAT_W'(want.granted_slot), STAT_W'(got.granted_slot));
        note_field("pool_capacity", STAT_W'(want.pool_capacity), STAT_W'(got.pool_capacity));
        note_field("blocks_in_use", STAT_W'(want.blocks_in_use), STAT_W'(got.blocks_in_use));
        note_field("blocks_available", STAT_W'(want.blocks_available),
                   STAT_W'(got.blocks_available));
        note_field("alloc_count", want.alloc_count, got.alloc_count);
        note_field("free_count", want.free_count, got.free_count);
        note_field("failure_count", want.failure_count, got.failure_count);
        note_field("peak_in_use", STAT_W'(want.peak_in_use), STAT_W'(got.peak_in_use));
        note_field("healthy", STAT_W'(want.healthy), STAT_W'(got.healthy));
        checked++;
    endtask

    initial
    begin
        int gap;
        alloc_rsp_t got;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            got = rsp;
            if (pending.size() == 0)
            begin
                $display("%0t: response with no request outstanding, expected none, actual status %0d",
                         $time, got.status);
                errors++;
            end
            else
            begin
                compare_response(pending.pop_front(), got);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timed out with %0d responses outstanding", $time, pending.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        alloc_req_t q;
        alloc_rsp_t typed_rsp;
        alloc_req_t blank;
        alloc_rsp_t none;
        logic [NUM_REGS-1:0][COUNT_W-1:0] counts;
        int alloc_share;
        blank = '0;
        none  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_pools(DIRECTED_POOLS);
        foreach (DIRECTED_ROWS[i])
        begin
            q = '0;
            q.kind          = DIRECTED_ROWS[i].kind;
            q.request_bytes = DIRECTED_ROWS[i].request_bytes;
            q.size_class    = DIRECTED_ROWS[i].size_class;
            q.block_slot    = DIRECTED_ROWS[i].block_slot;
            typed_rsp = '0;
            typed_rsp.status        = DIRECTED_ROWS[i].status;
            typed_rsp.granted_class = DIRECTED_ROWS[i].class_out;
            typed_rsp.healthy       = DIRECTED_ROWS[i].healthy;
            send_request(q, DIRECTED_ROWS[i].typed, typed_rsp);
        end

        for (int p = 0; p <= NUM_PLANS; p++)
        begin
            drain();
            if (p < NUM_PLANS)
            begin
                counts = POOL_PLANS[p];
            end
            else
            begin
                for (int r = REG_BLOCKS_CLASS0; r <= REG_BLOCKS_CLASS3; r++)
                    counts[r] = COUNT_W'($urandom_range(0, 127));
            end
            set_pools(counts);
            steady = ($urandom_range(0, 3) == 0);
            if (pools_up)
            begin
                blank.kind = KIND_DEINIT;
                send_request(blank, 1'b0, none);
            end
            blank.kind = KIND_INIT;
            send_request(blank, 1'b0, none);
            alloc_share = $urandom_range(30, 55);
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 49) == 0)
                    steady = !steady;
                send_request(next_request(alloc_share), 1'b0, none);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Checked %0d responses to %0d requests over %0d pool settings.",
                 checked, sent, settings_done);
        $display("Saw %0d grants, %0d exhausted pools, %0d rejected frees, %0d unhealthy replies.",
                 grants, exhausted, rejected_frees, unhealthy);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
